>>> rtl/core/amc_pkg.sv
package amc_pkg;

  localparam int SampleWidth = 14;
  localparam int AccWidth    = 24;
  localparam int SqWidth     = 2 * AccWidth + 2;
  localparam int RootSteps   = SqWidth / 2;

  localparam logic [2:0] ModeFreeFall = 3'd0;
  localparam logic [2:0] ModeTilt     = 3'd1;
  localparam logic [2:0] ModeStep     = 3'd2;
  localparam logic [2:0] ModeVel3d    = 3'd3;
  localparam logic [2:0] ModeVel2d    = 3'd4;

  localparam logic [2:0] RegMode      = 3'd0;
  localparam logic [2:0] RegRange     = 3'd1;
  localparam logic [2:0] RegStepThr   = 3'd2;
  localparam logic [2:0] RegFfLimit   = 3'd3;
  localparam logic [2:0] RegMotionThr = 3'd4;
  localparam logic [2:0] RegHoldoff   = 3'd5;

  typedef struct packed {
    logic [2:0]  mode;
    logic [1:0]  range_select;
    logic [9:0]  step_threshold;
    logic [10:0] freefall_limit;
    logic [9:0]  motion_threshold;
    logic [7:0]  step_holdoff;
  } cfg_t;

  typedef struct packed {
    logic load;    // capture sample, scale it
    logic update;  // classify and update state
    logic sq_step; // one square-sum term
    logic root_start;
    logic root_step;
  } cmd_t;

  typedef struct packed {
    logic root_last;
  } root_flags_t;

  typedef struct packed {
    logic [9:0]  tilt_x;
    logic [9:0]  tilt_y;
    logic [10:0] tilt_z;
    logic        free_fall;
    logic        step_event;
    logic [15:0] step_count;
    logic [AccWidth-1:0] vel_x;
    logic [AccWidth-1:0] vel_y;
    logic [AccWidth-1:0] vel_z;
    logic [AccWidth-1:0] speed_magnitude;
  } result_t;

endpackage

>>> rtl/core/amc_stream_if.sv
interface amc_in_if;
  import amc_pkg::*;
  logic valid;
  logic ready;
  logic signed [SampleWidth-1:0] accel_x;
  logic signed [SampleWidth-1:0] accel_y;
  logic signed [SampleWidth-1:0] accel_z;
  modport source (output valid, accel_x, accel_y, accel_z, input ready);
  modport sink (input valid, accel_x, accel_y, accel_z, output ready);
endinterface

interface amc_out_if;
  import amc_pkg::*;
  logic valid;
  logic ready;
  logic [9:0]  tilt_x;
  logic [9:0]  tilt_y;
  logic signed [10:0] tilt_z;
  logic        free_fall;
  logic        step_event;
  logic [15:0] step_count;
  logic signed [AccWidth-1:0] vel_x;
  logic signed [AccWidth-1:0] vel_y;
  logic signed [AccWidth-1:0] vel_z;
  logic [AccWidth-1:0] speed_magnitude;
  modport source (output valid, tilt_x, tilt_y, tilt_z, free_fall, step_event, step_count,
                  vel_x, vel_y, vel_z, speed_magnitude, input ready);
  modport sink (input valid, tilt_x, tilt_y, tilt_z, free_fall, step_event, step_count,
                vel_x, vel_y, vel_z, speed_magnitude, output ready);
endinterface

>>> rtl/core/amc_datapath.sv
module amc_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  amc_pkg::cfg_t                  cfg,
  input  amc_pkg::cmd_t                  cmd,
  input  logic [1:0]                     sq_sel,
  input  logic signed [amc_pkg::SampleWidth-1:0] accel_x,
  input  logic signed [amc_pkg::SampleWidth-1:0] accel_y,
  input  logic signed [amc_pkg::SampleWidth-1:0] accel_z,
  output amc_pkg::result_t               result
);
  import amc_pkg::*;

  localparam int ProdW = SampleWidth + 11;
  localparam int Sh    = SampleWidth - 1;
  localparam int RootW = $clog2(RootSteps + 1);

  logic [6:0] gain;
  logic signed [ProdW-1:0] px, py, pz;
  logic signed [10:0] sx, sy, sz;
  logic signed [10:0] x, y, z;
  logic [9:0] ax, ay, az;

  logic [15:0] step_counter;
  logic [7:0]  holdoff_counter;
  logic signed [AccWidth-1:0] velocity_x, velocity_y, velocity_z;
  logic free_fall, step_event;

  logic [SqWidth-1:0] sq_acc;
  logic [SqWidth-1:0] rem;
  logic [AccWidth:0]  root;
  logic [RootW-1:0]   root_cnt;

  // gain = log2(g) - 1; product is v*90*g; arithmetic shift floors toward minus infinity
  always_comb begin
    case (cfg.range_select)
      2'd0:    gain = 7'd0;
      2'd1:    gain = 7'd1;
      default: gain = 7'd2;
    endcase
    px = ProdW'(accel_x) * ProdW'(signed'(8'd90));
    py = ProdW'(accel_y) * ProdW'(signed'(8'd90));
    pz = ProdW'(accel_z) * ProdW'(signed'(8'd90));
    sx = 11'(((px <<< gain) <<< 1) >>> Sh);
    sy = 11'(((py <<< gain) <<< 1) >>> Sh);
    sz = 11'(((pz <<< gain) <<< 1) >>> Sh);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x <= sx;
      y <= sy;
      z <= sz;
    end
  end

  assign ax = 10'(x[10] ? -x : x);
  assign ay = 10'(y[10] ? -y : y);
  assign az = 10'(z[10] ? -z : z);

  function automatic logic signed [AccWidth-1:0] sat_add(
    input logic signed [AccWidth-1:0] a, input logic signed [11:0] b);
    logic signed [AccWidth:0] s;
    s = (AccWidth+1)'(a) + (AccWidth+1)'(b);
    if (s[AccWidth] != s[AccWidth-1])
      return s[AccWidth] ? {1'b1, {(AccWidth-1){1'b0}}} : {1'b0, {(AccWidth-1){1'b1}}};
    return s[AccWidth-1:0];
  endfunction

  logic [20:0] sum_sq;
  logic [19:0] thr_sq;
  logic step_hit, moving, vel_mode;
  logic [11:0] abs_sum;
  always_comb begin
    sum_sq = 21'(ax * ax) + 21'(ay * ay) + 21'(az * az);
    thr_sq = cfg.step_threshold * cfg.step_threshold;
    step_hit = (holdoff_counter == 8'd0) && (cfg.mode == ModeStep) &&
               (sum_sq > 21'(thr_sq));
    abs_sum = 12'(ax) + 12'(ay) + 12'(az);
    vel_mode = (cfg.mode == ModeVel3d) || (cfg.mode == ModeVel2d);
    moving = (ax > cfg.motion_threshold) || (ay > cfg.motion_threshold);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_counter <= '0;
      holdoff_counter <= '0;
      velocity_x <= '0;
      velocity_y <= '0;
      velocity_z <= '0;
    end else if (cmd.update) begin
      if (holdoff_counter != 8'd0) holdoff_counter <= holdoff_counter - 8'd1;
      else if (step_hit) holdoff_counter <= cfg.step_holdoff;
      if (step_hit && step_counter != 16'hFFFF) step_counter <= step_counter + 16'd1;
      if (vel_mode && moving) begin
        velocity_x <= sat_add(velocity_x, 12'(x));
        velocity_y <= sat_add(velocity_y, 12'(y));
        if (cfg.mode == ModeVel3d) velocity_z <= sat_add(velocity_z, 12'(z) - 12'sd90);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      free_fall  <= (cfg.mode == ModeFreeFall) && (abs_sum < 12'(cfg.freefall_limit));
      step_event <= step_hit;
    end
  end

  // square sum: one squared term per cycle
  logic signed [AccWidth-1:0] sq_in;
  logic [AccWidth-1:0] sq_abs;
  always_comb begin
    case (sq_sel)
      2'd0:    sq_in = velocity_x;
      2'd1:    sq_in = velocity_y;
      default: sq_in = velocity_z;
    endcase
    sq_abs = sq_in[AccWidth-1] ? AccWidth'(-sq_in) : AccWidth'(sq_in);
    if (sq_in == {1'b1, {(AccWidth-1){1'b0}}}) sq_abs = {1'b1, {(AccWidth-1){1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (cmd.update) sq_acc <= '0;
    else if (cmd.sq_step) sq_acc <= sq_acc + SqWidth'(sq_abs * sq_abs);
  end

  // restoring square root, one result bit per cycle; trial term is (4r+1) << 2k
  logic [SqWidth-1:0] trial;
  logic [AccWidth+2:0] root_try;
  always_comb begin
    root_try = {root, 2'b01};
    trial = SqWidth'(root_try) << (2 * root_cnt);
  end

  always_ff @(posedge clk) begin
    if (cmd.root_start) begin
      rem <= sq_acc;
      root <= '0;
      root_cnt <= RootW'(RootSteps - 1);
    end else if (cmd.root_step) begin
      if (rem >= trial) begin
        rem  <= rem - trial;
        root <= {root[AccWidth-1:0], 1'b1};
      end else begin
        root <= {root[AccWidth-1:0], 1'b0};
      end
      root_cnt <= root_cnt - RootW'(1);
    end
  end

  assign result.tilt_x = ax;
  assign result.tilt_y = ay;
  assign result.tilt_z = z;
  assign result.free_fall = free_fall;
  assign result.step_event = step_event;
  assign result.step_count = step_counter;
  assign result.vel_x = velocity_x;
  assign result.vel_y = velocity_y;
  assign result.vel_z = velocity_z;
  assign result.speed_magnitude = vel_mode ? root[AccWidth-1:0] : '0;
endmodule

>>> rtl/core/amc_controller.sv
module amc_controller (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [2:0]           mode,
  input  logic                 in_fire,
  input  logic                 out_busy,
  input  logic                 out_fire,
  output logic                 in_ready,
  output logic                 out_valid,
  output logic [1:0]           sq_sel,
  output amc_pkg::cmd_t        cmd
);
  import amc_pkg::*;

  typedef enum logic [5:0] {
    StIdle   = 6'b000001,
    StUpdate = 6'b000010,
    StSquare = 6'b000100,
    StRoot   = 6'b001000,
    StOut    = 6'b010000,
    StHold   = 6'b100000
  } state_t;

  localparam int CntW = $clog2(RootSteps + 1);

  state_t state, state_next;
  logic [CntW-1:0] cnt;

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.load = in_fire;
    case (state)
      StIdle:   if (in_fire) state_next = StUpdate;
      StUpdate: begin
        cmd.update = 1'b1;
        state_next = StSquare;
      end
      StSquare: begin
        cmd.sq_step = 1'b1;
        if (cnt == CntW'(2) || (cnt == CntW'(1) && mode != ModeVel3d)) begin
          state_next = StRoot;
        end
      end
      StRoot: begin
        if (cnt == '0) cmd.root_start = 1'b1;
        else cmd.root_step = 1'b1;
        if (cnt == CntW'(RootSteps)) state_next = StOut;
      end
      StOut:    if (!out_busy) state_next = StHold;
      StHold:   if (out_fire) state_next = StIdle;
      default:  state_next = StIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
      cnt <= '0;
    end else begin
      state <= state_next;
      if (state != state_next) cnt <= '0;
      else cnt <= cnt + CntW'(1);
    end
  end

  assign sq_sel = cnt[1:0];
  assign in_ready = (state == StIdle);
  assign out_valid = (state == StHold);
endmodule

>>> rtl/core/accel_motion_classifier_unit.sv
// Accelerometer motion classifier. One sample in, one result out, one
// sample at a time. After the input transfer the block runs an update
// step, a square-sum of the x and y velocity accumulators (z as well in
// the 3D velocity mode), a root load step plus 25 bit-serial square root
// steps, and an output step. The result then waits in place until its
// transfer completes, and only then is the next sample taken. Scaling,
// free fall, step detection with holdoff and saturating velocity sums follow
// the selected mode; the square root runs in every mode but is shown only in
// the velocity modes. Registers sit on an APB port at byte addresses 4*i
// (mode, range_select, step_threshold, freefall_limit, motion_threshold,
// step_holdoff); the user must write them only while idle, which the block
// does not enforce; pready is tied high.
module accel_motion_classifier_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  amc_in_if.sink      in_ch,
  amc_out_if.source   out_ch
);
  import amc_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  result_t result;
  logic [1:0] sq_sel;
  logic [2:0] reg_idx;

  assign pready = 1'b1;
  assign reg_idx = paddr[4:2];

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode <= ModeTilt;
      cfg.range_select <= 2'd0;
      cfg.step_threshold <= 10'd120;
      cfg.freefall_limit <= 11'd10;
      cfg.motion_threshold <= 10'd5;
      cfg.step_holdoff <= 8'd0;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      case (reg_idx)
        RegMode:      cfg.mode <= pwdata[2:0];
        RegRange:     cfg.range_select <= pwdata[1:0];
        RegStepThr:   cfg.step_threshold <= pwdata[9:0];
        RegFfLimit:   cfg.freefall_limit <= pwdata[10:0];
        RegMotionThr: cfg.motion_threshold <= pwdata[9:0];
        RegHoldoff:   cfg.step_holdoff <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegMode:      prdata = 32'(cfg.mode);
      RegRange:     prdata = 32'(cfg.range_select);
      RegStepThr:   prdata = 32'(cfg.step_threshold);
      RegFfLimit:   prdata = 32'(cfg.freefall_limit);
      RegMotionThr: prdata = 32'(cfg.motion_threshold);
      RegHoldoff:   prdata = 32'(cfg.step_holdoff);
      default:      prdata = '0;
    endcase
  end

  amc_controller u_ctrl (
    .clk, .rst,
    .mode(cfg.mode),
    .in_fire(in_ch.valid && in_ch.ready),
    .out_busy(1'b0),
    .out_fire(out_ch.valid && out_ch.ready),
    .in_ready(in_ch.ready),
    .out_valid(out_ch.valid),
    .sq_sel,
    .cmd
  );

  amc_datapath u_dp (
    .clk, .rst, .cfg, .cmd, .sq_sel,
    .accel_x(in_ch.accel_x),
    .accel_y(in_ch.accel_y),
    .accel_z(in_ch.accel_z),
    .result
  );

  assign out_ch.tilt_x = result.tilt_x;
  assign out_ch.tilt_y = result.tilt_y;
  assign out_ch.tilt_z = result.tilt_z;
  assign out_ch.free_fall = result.free_fall;
  assign out_ch.step_event = result.step_event;
  assign out_ch.step_count = result.step_count;
  assign out_ch.vel_x = result.vel_x;
  assign out_ch.vel_y = result.vel_y;
  assign out_ch.vel_z = result.vel_z;
  assign out_ch.speed_magnitude = result.speed_magnitude;
endmodule

>>> sim/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import amc_pkg::*;

  // Predictor of the classifier plus the queue of results still owed by the block.
  class motion_scoreboard;
    bit [2:0]  mode;
    bit [1:0]  range_sel;
    bit [9:0]  step_thr;
    bit [10:0] ff_limit;
    bit [9:0]  motion_thr;
    bit [7:0]  holdoff_load;
    bit [15:0] steps;
    bit [7:0]  holdoff;
    longint    vx, vy, vz;
    result_t   pending_results[$];
    int        errors;

    function new();
      mode = ModeTilt; range_sel = 0; step_thr = 120; ff_limit = 10;
      motion_thr = 5; holdoff_load = 0; steps = 0; holdoff = 0;
      vx = 0; vy = 0; vz = 0; errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, bit [31:0] v);
      case (idx)
        RegMode:      mode = v[2:0];
        RegRange:     range_sel = v[1:0];
        RegStepThr:   step_thr = v[9:0];
        RegFfLimit:   ff_limit = v[10:0];
        RegMotionThr: motion_thr = v[9:0];
        RegHoldoff:   holdoff_load = v[7:0];
        default: ;
      endcase
    endfunction

    // floor(v*g*90/8192)
    function longint scale_axis(logic signed [13:0] v, int g);
      longint p;
      p = longint'(v) * g * 90;
      return p >>> 13;
    endfunction

    function longint sat24(longint s);
      if (s > 64'sd8388607) return 64'sd8388607;
      if (s < -64'sd8388608) return -64'sd8388608;
      return s;
    endfunction

    function longint unsigned floor_root(longint unsigned n);
      longint unsigned r, t;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
        t = r | (64'd1 << b);
        if (t * t <= n) r = t;
      end
      return r;
    endfunction

    // Accepted sample: advance state and queue the expected result.
    function void note_sample(logic signed [13:0] sx, logic signed [13:0] sy,
                              logic signed [13:0] sz);
      int g;
      longint x, y, z, ax, ay, az;
      longint unsigned mag;
      result_t r;
      g = (range_sel == 0) ? 2 : (range_sel == 1) ? 4 : 8;
      x = scale_axis(sx, g);
      y = scale_axis(sy, g);
      z = scale_axis(sz, g);
      ax = x < 0 ? -x : x;
      ay = y < 0 ? -y : y;
      az = z < 0 ? -z : z;
      mag = 0;
      r = '0;
      r.free_fall = (mode == ModeFreeFall) && (ax + ay + az < ff_limit);
      if (holdoff != 0) begin
        holdoff--;
      end else if (mode == ModeStep) begin
        if (x * x + y * y + z * z > longint'(step_thr) * step_thr) begin
          r.step_event = 1'b1;
          if (steps != 16'hFFFF) steps++;
          holdoff = holdoff_load;
        end
      end
      if (mode == ModeVel3d || mode == ModeVel2d) begin
        if (ax > motion_thr || ay > motion_thr) begin
          vx = sat24(vx + x);
          vy = sat24(vy + y);
          if (mode == ModeVel3d) vz = sat24(vz + z - 90);
        end
        if (mode == ModeVel3d) mag = floor_root(vx * vx + vy * vy + vz * vz);
        else mag = floor_root(vx * vx + vy * vy);
      end
      r.tilt_x = ax[9:0];
      r.tilt_y = ay[9:0];
      r.tilt_z = z[10:0];
      r.step_count = steps;
      r.vel_x = vx[23:0];
      r.vel_y = vy[23:0];
      r.vel_z = vz[23:0];
      r.speed_magnitude = mag[23:0];
      pending_results.push_back(r);
    endfunction

    function void cmp(string name, longint expd, longint act);
      if (expd != act) begin
        $error("%s mismatch: expected %0d, got %0d", name, expd, act);
        errors++;
      end
    endfunction

    function void check_result(result_t a);
      result_t e;
      if (pending_results.size() == 0) begin
        $error("result with no sample outstanding");
        errors++;
        return;
      end
      e = pending_results.pop_front();
      cmp("tilt_x", e.tilt_x, a.tilt_x);
      cmp("tilt_y", e.tilt_y, a.tilt_y);
      cmp("tilt_z", e.tilt_z, a.tilt_z);
      cmp("free_fall", e.free_fall, a.free_fall);
      cmp("step_event", e.step_event, a.step_event);
      cmp("step_count", e.step_count, a.step_count);
      cmp("vel_x", e.vel_x, a.vel_x);
      cmp("vel_y", e.vel_y, a.vel_y);
      cmp("vel_z", e.vel_z, a.vel_z);
      cmp("speed_magnitude", e.speed_magnitude, a.speed_magnitude);
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  amc_in_if  in_ch ();
  amc_out_if out_ch ();

  accel_motion_classifier_unit i_dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_ch   (in_ch.sink),
    .out_ch  (out_ch.source)
  );

  motion_scoreboard sb = new();

  // Idle knobs in percent (gap per sample, stall per cycle); receiver hold-off counted in its process.
  int unsigned send_gap_pct;
  int unsigned stall_pct;
  int unsigned hold_cycles;
  int unsigned quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Receiver: random stalls, plus one long hold-off so the block backs up.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles != 0) begin
        out_ch.ready <= 1'b0;
        hold_cycles--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Result checking at the rising edge.
  always @(posedge clk) begin
    result_t a;
    if (!rst && out_ch.valid && out_ch.ready) begin
      a.tilt_x = out_ch.tilt_x;
      a.tilt_y = out_ch.tilt_y;
      a.tilt_z = out_ch.tilt_z;
      a.free_fall = out_ch.free_fall;
      a.step_event = out_ch.step_event;
      a.step_count = out_ch.step_count;
      a.vel_x = out_ch.vel_x;
      a.vel_y = out_ch.vel_y;
      a.vel_z = out_ch.vel_z;
      a.speed_magnitude = out_ch.speed_magnitude;
      sb.check_result(a);
    end
  end

  // Watchdog: too long without any transfer or register access ends the run.
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= 20000) begin
        $display("** accel_motion_classifier_unit: FAILED **");
        $finish;
      end
    end
  end

  // APB write: setup cycle, then access cycle; the write lands at the end of the access cycle.
  // The task then drops psel and waits idle before returning, so back-to-back writes never collide.
  task automatic write_reg(logic [2:0] idx, bit [31:0] v);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    sb.set_reg(idx, v);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(negedge clk);
  endtask

  task automatic write_all(bit [2:0] m, bit [1:0] rs, bit [9:0] st, bit [10:0] ff,
                           bit [9:0] mt, bit [7:0] ho);
    write_reg(RegMode, m);
    write_reg(RegRange, rs);
    write_reg(RegStepThr, st);
    write_reg(RegFfLimit, ff);
    write_reg(RegMotionThr, mt);
    write_reg(RegHoldoff, ho);
  endtask

  // One sample transfer; called and returns at a falling edge.
  task automatic send_sample(logic signed [13:0] x, logic signed [13:0] y,
                             logic signed [13:0] z);
    if ($urandom_range(99) < send_gap_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.accel_x <= x; in_ch.accel_y <= y; in_ch.accel_z <= z;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_sample(x, y, z);
    @(negedge clk);
  endtask

  // Wait for all owed results, then a margin so the block is surely idle.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  function automatic logic signed [13:0] rand_axis();
    case ($urandom_range(3))
      0: return 14'($urandom);
      1: return 14'($signed($urandom_range(800)) - 400);
      2: return 14'($signed($urandom_range(4000)) - 2000);
      default: return $urandom_range(1) ? 14'sh1FFF : -14'sd8192;
    endcase
  endfunction

  task automatic random_phase(int n, int scheme);
    bit [2:0] m;
    case (scheme % 4)
      0: begin send_gap_pct = 0;  stall_pct = 0;  end
      1: begin send_gap_pct = 54; stall_pct = 0;  end
      2: begin send_gap_pct = 0;  stall_pct = 54; end
      default: begin send_gap_pct = 25; stall_pct = 25; end
    endcase
    m = ($urandom_range(9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(4));
    if (scheme == 0)
      write_all(m, 2'd3, 10'd1023, 11'd2047, 10'd720, 8'd255);
    else if (scheme == 1)
      write_all(m, 2'd0, 10'd0, 11'd0, 10'd0, 8'd0);
    else
      write_all(m, 2'($urandom_range(3)), 10'($urandom_range(1023)),
                11'($urandom_range(2047)), 10'($urandom_range(720)),
                8'($urandom_range(8)));
    for (int i = 0; i < n; i++) begin
      send_sample(rand_axis(), rand_axis(), rand_axis());
      // occasional mode change, only while idle
      if ($urandom_range(39) == 0) begin
        drain();
        write_reg(RegMode, 3'($urandom_range(4)));
      end
    end
    drain();
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_ch.valid = 1'b0; in_ch.accel_x = '0; in_ch.accel_y = '0; in_ch.accel_z = '0;
    send_gap_pct = 0; stall_pct = 0; hold_cycles = 0; quiet_cycles = 0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: reset configuration first, then every mode incl. unused ones,
    // every range code incl. the unused one, extremes of the samples.
    send_sample(14'sh1FFF, -14'sd8192, 14'sd0);
    send_sample(-14'sd1, 14'sd1, -14'sd8192);
    drain();
    write_reg(RegHoldoff, 8'd2);
    for (int m = 0; m < 8; m++) begin
      write_reg(RegMode, 3'(m));
      write_reg(RegRange, 2'(m % 4));
      send_sample(14'sh1FFF, 14'sh1FFF, 14'sh1FFF);
      send_sample(-14'sd8192, -14'sd8192, -14'sd8192);
      send_sample(14'sd0, 14'sd0, 14'sd0);
      drain();
    end

    // Random phases cycling through the idle schemes.
    for (int p = 0; p < 12; p++) begin
      if (p == 5) begin
        // receiver holds off long while the sender keeps offering
        hold_cycles = 400;
      end
      if (p == 6) begin
        random_phase(50, p);
        // sender pause until everything owed has come back
        drain();
      end
      random_phase(105, p);
    end

    // Velocity modes at full scale, back to back: 3D with x, y up and z down, then 2D with x up and y down.
    send_gap_pct = 0; stall_pct = 0;
    write_all(ModeVel3d, 2'd2, 10'd0, 11'd0, 10'd0, 8'd0);
    for (int i = 0; i < 10; i++) send_sample(14'sh1FFF, 14'sh1FFF, -14'sd8192);
    drain();
    write_reg(RegMode, ModeVel2d);
    for (int i = 0; i < 10; i++) send_sample(14'sh1FFF, -14'sd8192, 14'sd0);
    drain();

    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("** accel_motion_classifier_unit: PASSED **");
    end else begin
      $display("** accel_motion_classifier_unit: FAILED **");
    end
    $finish;
  end

endmodule

>>> accel_motion_classifier_unit.f
rtl/core/amc_pkg.sv
rtl/core/amc_stream_if.sv
rtl/core/amc_datapath.sv
rtl/core/amc_controller.sv
rtl/core/accel_motion_classifier_unit.sv
sim/testbench.sv
